// File: rtl/rcfp_pkg.sv
// Shared constants, state type and CRC step for the RC channel frame packer.
package rcfp_pkg;

	localparam int NumChannels  = 16;
	localparam int ChanWidth    = 11;
	localparam int PackedBits   = NumChannels * ChanWidth;
	localparam int PayloadBytes = PackedBits / 8;
	localparam int FrameBytes   = PayloadBytes + 4;
	localparam int IdxWidth     = $clog2(FrameBytes);
	localparam int CntWidth     = $clog2(NumChannels);

	localparam logic [7:0] AddrReset = 8'hCE;
	localparam logic [7:0] LenByte   = 8'd24;
	localparam logic [7:0] TypeByte  = 8'h16;
	localparam logic [7:0] CrcPoly   = 8'hD5;

	// byte positions within a frame
	localparam logic [IdxWidth-1:0] IdxAddr = IdxWidth'(0);
	localparam logic [IdxWidth-1:0] IdxLen  = IdxWidth'(1);
	localparam logic [IdxWidth-1:0] IdxType = IdxWidth'(2);
	localparam logic [IdxWidth-1:0] IdxCrc  = IdxWidth'(FrameBytes - 1);

	localparam logic [CntWidth-1:0] LastChan = CntWidth'(NumChannels - 1);

	typedef enum logic [0:0] {
		ST_COLLECT,
		ST_EMIT
	} state_t;

	// one byte through the CRC-8, MSB first, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7])
				c = {c[6:0], 1'b0} ^ CrcPoly;
			else
				c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: rtl/rcfp_crc8.sv
// Running CRC-8 register, one byte folded in per update.
module rcfp_crc8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic       update,
	input  logic [7:0] data,
	output logic [7:0] crc
);

	logic [7:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 8'h00;
		end else if (clear) begin
			crc_q <= 8'h00;
		end else if (update) begin
			crc_q <= rcfp_pkg::crc8_byte(crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule

// File: rtl/rc_channel_frame_packer.sv
// Top level: collects sixteen channel values and sends them out as a CRC-protected frame.
//
// Usage:
//   s_axis carries one 11-bit channel value per item, channels 0 to 15 in order.
//   Items 1 to 15 of a frame are stored and produce nothing.
//   The sixteenth item starts a 26-byte frame on m_axis: address, length 24,
//   type 0x16, 22 bytes of channels packed little-endian at 11 bits, CRC-8.
//   tlast marks the CRC byte.
//   While the frame is sent, s_axis_tready is low; the sequencer issues one
//   byte per cycle into the output register when m_axis does not stall. After
//   the sixteenth item is accepted, the sequencer enters ST_EMIT and then
//   loads the address byte into the output register. The packed channels
//   leave a 176-bit shift line 8 bits per payload byte, and one CRC unit
//   folds in the type byte and each payload byte as it is issued.
//   A stalled m_axis holds the current byte and the sequencer waits.
//   s_axis opens again as soon as the CRC byte is in the output register.
//   cfg_wr_en/cfg_wr_data set the address byte; write only while idle.
//   Reset clears the channel count, the sequencer and the output valid, and
//   sets the address to 0xCE.
module rc_channel_frame_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [10:0] channel_value, [15:11] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] frame_byte
	output logic        m_axis_tlast   // last_byte
);

	localparam int PackedBits = rcfp_pkg::PackedBits;
	localparam int ChanWidth  = rcfp_pkg::ChanWidth;
	localparam int IdxWidth   = rcfp_pkg::IdxWidth;
	localparam int CntWidth   = rcfp_pkg::CntWidth;

	rcfp_pkg::state_t state_q, state_d;

	logic [7:0]            dest_q;
	logic [CntWidth-1:0]   chan_cnt_q;
	logic [IdxWidth-1:0]   byte_idx_q, byte_idx_d;
	logic [PackedBits-1:0] pack_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;
	logic                  out_valid_q;

	logic       in_take;
	logic       emit_go;
	logic       frame_start;
	logic [7:0] byte_sel;
	logic       is_payload;
	logic       crc_clear;
	logic       crc_update;
	logic [7:0] crc_val;

	assign in_take     = s_axis_tvalid && s_axis_tready;
	assign frame_start = in_take && (chan_cnt_q == rcfp_pkg::LastChan);
	assign emit_go     = (state_q == rcfp_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);
	assign is_payload  = (byte_idx_q > rcfp_pkg::IdxType) && (byte_idx_q < rcfp_pkg::IdxCrc);

	// byte selection for the current frame position
	always_comb begin
		if (byte_idx_q == rcfp_pkg::IdxAddr)
			byte_sel = dest_q;
		else if (byte_idx_q == rcfp_pkg::IdxLen)
			byte_sel = rcfp_pkg::LenByte;
		else if (byte_idx_q == rcfp_pkg::IdxType)
			byte_sel = rcfp_pkg::TypeByte;
		else if (byte_idx_q == rcfp_pkg::IdxCrc)
			byte_sel = crc_val;
		else
			byte_sel = pack_q[7:0];
	end

	// CRC covers the type byte and the payload
	assign crc_clear  = emit_go && (byte_idx_q == rcfp_pkg::IdxAddr);
	assign crc_update = emit_go && ((byte_idx_q == rcfp_pkg::IdxType) || is_payload);

	rcfp_crc8 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (crc_clear),
		.update (crc_update),
		.data   (byte_sel),
		.crc    (crc_val)
	);

	// sequencer
	always_comb begin
		state_d    = state_q;
		byte_idx_d = byte_idx_q;
		unique case (state_q)
			rcfp_pkg::ST_COLLECT: begin
				byte_idx_d = rcfp_pkg::IdxAddr;
				if (frame_start)
					state_d = rcfp_pkg::ST_EMIT;
			end
			rcfp_pkg::ST_EMIT: begin
				if (emit_go) begin
					if (byte_idx_q == rcfp_pkg::IdxCrc) begin
						state_d    = rcfp_pkg::ST_COLLECT;
						byte_idx_d = rcfp_pkg::IdxAddr;
					end else begin
						byte_idx_d = byte_idx_q + IdxWidth'(1);
					end
				end
			end
			default: begin
				state_d    = rcfp_pkg::ST_COLLECT;
				byte_idx_d = rcfp_pkg::IdxAddr;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rcfp_pkg::ST_COLLECT;
			byte_idx_q <= rcfp_pkg::IdxAddr;
		end else begin
			state_q    <= state_d;
			byte_idx_q <= byte_idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q     <= rcfp_pkg::AddrReset;
			chan_cnt_q <= '0;
		end else begin
			if (cfg_wr_en)
				dest_q <= cfg_wr_data;
			if (in_take)
				chan_cnt_q <= chan_cnt_q + CntWidth'(1);
		end
	end

	// channels enter at the top, so channel 0 ends up in the low bits
	always_ff @(posedge clk) begin
		if (in_take)
			pack_q <= {s_axis_tdata[ChanWidth-1:0], pack_q[PackedBits-1:ChanWidth]};
		else if (emit_go && is_payload)
			pack_q <= {8'h00, pack_q[PackedBits-1:8]};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_byte_q <= byte_sel;
			out_last_q <= (byte_idx_q == rcfp_pkg::IdxCrc);
		end
	end

	assign s_axis_tready = (state_q == rcfp_pkg::ST_COLLECT);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
	a_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		frame_start |=> (state_q == rcfp_pkg::ST_EMIT) && (byte_idx_q == rcfp_pkg::IdxAddr))
		else $error("frame did not start after the sixteenth item");

	a_frame_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && (byte_idx_q == rcfp_pkg::IdxCrc)
			|=> (state_q == rcfp_pkg::ST_COLLECT) && m_axis_tvalid && m_axis_tlast)
		else $error("CRC byte not presented with tlast at end of frame");

	a_addr_first: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && (byte_idx_q == rcfp_pkg::IdxAddr) |=> m_axis_tdata == $past(dest_q))
		else $error("first frame byte is not the address");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcfp_pkg::ST_COLLECT) |-> (byte_idx_q == rcfp_pkg::IdxAddr))
		else $error("byte index not parked while collecting");
`endif

endmodule

// File: dv/tb_rc_channel_frame_packer.sv
// Testbench for rc_channel_frame_packer: random stream stimulus, frame predictor and byte checker.
`timescale 1ns / 100ps

module tb_rc_channel_frame_packer;
	import rcfp_pkg::*;

	localparam int StallLimit   = 2000;
	localparam int SettleCycles = 4;
	localparam int HoldCycles   = 200;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [10:0] channel_value, [15:11] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [7:0] frame_byte
	logic        m_axis_tlast;   // last_byte

	// predictor state
	logic [ChanWidth-1:0] channel_shadow [NumChannels];
	logic [CntWidth-1:0]  next_channel;
	logic [7:0]           addr_shadow;
	frame_byte_t          bytes_due [$];

	int sender_max_gap  = 3;
	int recv_max_stall  = 3;
	int hold_off_cycles = 0;
	int mismatch_count  = 0;
	int items_sent      = 0;
	int bytes_checked   = 0;
	int addr_writes     = 0;
	int idle_cycles     = 0;

	rc_channel_frame_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// bit-serial form of the CRC-8, MSB first
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ data[i];
			c  = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
		end
		return c;
	endfunction

	function automatic void queue_frame();
		logic [PackedBits-1:0] chan_bits;
		logic [7:0]            frame [FrameBytes];
		logic [7:0]            crc;
		frame_byte_t           fb;
		for (int ch = 0; ch < NumChannels; ch++)
			chan_bits[ch*ChanWidth +: ChanWidth] = channel_shadow[ch];
		frame[0] = addr_shadow;
		frame[1] = LenByte;
		frame[2] = TypeByte;
		for (int k = 0; k < PayloadBytes; k++)
			frame[3 + k] = chan_bits[k*8 +: 8];
		crc = 8'h00;
		for (int k = 2; k < FrameBytes - 1; k++)
			crc = crc_fold(crc, frame[k]);
		frame[FrameBytes - 1] = crc;
		for (int k = 0; k < FrameBytes; k++) begin
			fb.value = frame[k];
			fb.last  = (k == FrameBytes - 1);
			bytes_due.push_back(fb);
		end
	endfunction

	function automatic void record_channel(input logic [ChanWidth-1:0] value);
		channel_shadow[next_channel] = value;
		next_channel = next_channel + 1'b1;
		items_sent++;
		if (next_channel == '0)
			queue_frame();
	endfunction

	// entered just after the clock rises; leaves tvalid high once the item has been accepted
	task automatic send_channel(input logic [ChanWidth-1:0] value);
		int gap;
		gap = $urandom_range(0, sender_max_gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(16 - ChanWidth){1'b0}}, value};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		record_channel(value);
	endtask

	task automatic send_random_channels(input int count);
		for (int i = 0; i < count; i++)
			send_channel(ChanWidth'($urandom_range(0, (1 << ChanWidth) - 1)));
	endtask

	// sender goes quiet until every predicted byte is out
	task automatic drain_frames();
		s_axis_tvalid <= 1'b0;
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_address(input logic [7:0] addr);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= addr;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		addr_shadow = addr;
		addr_writes++;
	endtask

	// extremes of the channel value at the reset address; every bit both ways
	task automatic test_directed_frame();
		logic [ChanWidth-1:0] vals [NumChannels];
		vals = '{11'h000, 11'h7FF, 11'h001, 11'h400, 11'h555, 11'h2AA, 11'h002, 11'h004,
			11'h008, 11'h010, 11'h020, 11'h040, 11'h080, 11'h100, 11'h200, 11'h7FE};
		foreach (vals[i])
			send_channel(vals[i]);
		drain_frames();
	endtask

	// address at both ends and one random; the sender waits out each frame
	task automatic test_address_settings();
		logic [7:0] addrs [3];
		addrs = '{8'h00, 8'hFF, 8'($urandom_range(1, 254))};
		foreach (addrs[i]) begin
			write_address(addrs[i]);
			send_random_channels(NumChannels);
			drain_frames();
		end
	endtask

	// idling on both sides for half a frame, then a stretch with none
	task automatic test_random_frames();
		send_random_channels(NumChannels / 2);
		sender_max_gap = 0;
		recv_max_stall = 0;
		send_random_channels(NumChannels / 2);
		drain_frames();
		sender_max_gap = 3;
		recv_max_stall = 3;
	endtask

	// receiver holds off while two frames' worth of items keep coming
	task automatic test_output_hold();
		sender_max_gap  = 0;
		hold_off_cycles = HoldCycles;
		send_random_channels(2 * NumChannels);
		drain_frames();
		sender_max_gap = 3;
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_wr_data   <= 8'h00;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 16'h0000;
		m_axis_tready <= 1'b0;
		next_channel  = '0;
		addr_shadow   = AddrReset;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_frame();
		test_address_settings();
		test_random_frames();
		test_output_hold();

		repeat (32) @(posedge clk);
		$display("Sent %0d channel items, checked %0d frame bytes (%0d frames).",
			items_sent, bytes_checked, bytes_checked / FrameBytes);
		$display("Address written %0d times incl. 0x00 and 0xFF; one long output hold.",
			addr_writes);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// output side: random stall per item, or a long hold when one is requested
	initial begin : recv_proc
		int stall;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				stall = $urandom_range(0, recv_max_stall);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
		end
	end

	always @(posedge clk) begin : byte_check
		frame_byte_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (bytes_due.size() == 0) begin
				$display("%t: unexpected item: expected none, actual byte 0x%02h last %b",
					$time, m_axis_tdata, m_axis_tlast);
				mismatch_count++;
			end else begin
				due = bytes_due.pop_front();
				bytes_checked++;
				if (m_axis_tdata !== due.value) begin
					$display("%t: frame_byte expected 0x%02h actual 0x%02h",
						$time, due.value, m_axis_tdata);
					mismatch_count++;
				end
				if (m_axis_tlast !== due.last) begin
					$display("%t: last_byte expected %b actual %b",
						$time, due.last, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("%t: no item moved for %0d cycles, %0d bytes still due",
				$time, idle_cycles, bytes_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
